/* hw/rtl/cptb_pkg.sv */
package cptb_pkg;

    // Bank size and advance width.
    localparam int NUM_TIMERS = 4;
    localparam int CYCLE_BITS = 12;

    // Derived widths.
    localparam int TIDX_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W      = 16;
    localparam int ACC_W      = 10;
    localparam int TICK_W     = ((CYCLE_BITS > ACC_W) ? CYCLE_BITS : ACC_W) + 1;
    localparam int DIV_STEP_W = $clog2(TICK_W + 1);
    localparam int OVF_W      = 12;
    localparam int OVF_MAX    = 4095;
    localparam int IRQ_W      = 4;

    // Control word bit positions.
    localparam int CTL_CASCADE_BIT = 2;
    localparam int CTL_IRQ_BIT     = 6;
    localparam int CTL_EN_BIT      = 7;

    // Prescaler select codes.
    localparam logic [1:0] PS_DIV1    = 2'd0;
    localparam logic [1:0] PS_DIV64   = 2'd1;
    localparam logic [1:0] PS_DIV256  = 2'd2;
    localparam logic [1:0] PS_DIV1024 = 2'd3;

    // Item kinds.
    typedef enum logic [1:0] {
        KIND_CTRL    = 2'd0,
        KIND_RELOAD  = 2'd1,
        KIND_ADVANCE = 2'd2
    } kind_t;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_REPORT
    } state_t;

    // Status returned by the shared divider.
    typedef struct packed {
        logic              done;
        logic [TICK_W-1:0] quot;
        logic [CNT_W-1:0]  rem;
    } div_res_t;

    // Saturate an overflow count to the output range.
    function automatic logic [OVF_W-1:0] ovf_sat(input logic [TICK_W-1:0] n);
        if (32'(n) > OVF_MAX)
        begin
            ovf_sat = OVF_W'(OVF_MAX);
        end
        else
        begin
            ovf_sat = OVF_W'(n);
        end
    endfunction

endpackage

/* hw/rtl/cptb_div.sv */
module cptb_div
    import cptb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TICK_W-1:0] dividend,
    input  logic [CNT_W:0]    divisor,
    output div_res_t          res
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic [TICK_W-1:0]     quo_reg, quo_next;
    logic [CNT_W:0]        dsr_reg, dsr_next;

    logic [CNT_W:0]        trial;
    logic [CNT_W:0]        diff;
    logic                  ge;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb
    begin
        trial = {rem_reg, quo_reg[TICK_W-1]};
        diff  = trial - dsr_reg;
        ge    = (trial >= dsr_reg);
    end

    // Step sequencing.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = DIV_STEP_W'(TICK_W);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_next  = {quo_reg[TICK_W-2:0], ge};
            step_next = step_reg - DIV_STEP_W'(1);
            if (step_reg == DIV_STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign res.done = done_reg;
    assign res.quot = quo_reg;
    assign res.rem  = rem_reg;

    // A new division is only started once the previous one has finished.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    // Completion is flagged only after the last step.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    // While busy, steps remain.
    a_busy_steps: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg != '0)
        else $error("divider busy with no steps left");

endmodule

/* hw/rtl/cascaded_prescaled_timer_bank.sv */
// Sequence: a write item goes from ST_IDLE to ST_REPORT, which registers its result once the
// output is not stalled. An advance item visits ST_LOAD for each timer, and ST_DIV for each timer
// that wraps, then ST_REPORT.
// Throughput: one item at a time; the next item is taken the cycle after the result is
// registered. The wrap count of each timer comes from a shared 13-step restoring divider.
// Reset: rst_n clears all counters, reload values, control bits and prescalers at once.
module cascaded_prescaled_timer_bank
    import cptb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            kind,
    input  logic [1:0]            timer_index,
    input  logic [CNT_W-1:0]      write_value,
    input  logic [CYCLE_BITS-1:0] cycles,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [IRQ_W-1:0]      irq_raised,
    output logic [OVF_W-1:0]      timer0_overflows,
    output logic [OVF_W-1:0]      timer1_overflows,
    output logic [CNT_W-1:0]      counter_value
);

    localparam logic [CNT_W:0] WRAP = {1'b1, {CNT_W{1'b0}}};

    // Timer state.
    logic [CNT_W-1:0] cnt_reg     [NUM_TIMERS];
    logic [CNT_W-1:0] cnt_next    [NUM_TIMERS];
    logic [CNT_W-1:0] reload_reg  [NUM_TIMERS];
    logic [CNT_W-1:0] reload_next [NUM_TIMERS];
    logic [1:0]       sel_reg     [NUM_TIMERS];
    logic [1:0]       sel_next    [NUM_TIMERS];
    logic             cascade_reg [NUM_TIMERS];
    logic             cascade_next[NUM_TIMERS];
    logic             irq_en_reg  [NUM_TIMERS];
    logic             irq_en_next [NUM_TIMERS];
    logic             run_reg     [NUM_TIMERS];
    logic             run_next    [NUM_TIMERS];
    logic [ACC_W-1:0] acc_reg     [NUM_TIMERS];
    logic [ACC_W-1:0] acc_next    [NUM_TIMERS];

    // Sequencer and item registers.
    state_t                  state_reg, state_next;
    logic [TIDX_W-1:0]       k_reg, k_next;
    kind_t                   kind_reg, kind_next;
    logic [TIDX_W-1:0]       idx_reg, idx_next;
    logic                    idx_ok_reg, idx_ok_next;
    logic [CYCLE_BITS-1:0]   cycles_reg, cycles_next;
    logic [TICK_W-1:0]       kprev_reg, kprev_next;
    logic [IRQ_W-1:0]        irq_acc_reg, irq_acc_next;
    logic [OVF_W-1:0]        ovf0_reg, ovf0_next;
    logic [OVF_W-1:0]        ovf1_reg, ovf1_next;

    // Output register.
    logic                    out_valid_reg, out_valid_next;
    logic [IRQ_W-1:0]        irq_out_reg, irq_out_next;
    logic [OVF_W-1:0]        ovf0_out_reg, ovf0_out_next;
    logic [OVF_W-1:0]        ovf1_out_reg, ovf1_out_next;
    logic [CNT_W-1:0]        cnt_out_reg, cnt_out_next;

    // Shared timer read port and step datapath.
    logic [TIDX_W-1:0]       port_idx;
    logic                    port_idx_ok;
    logic [TIDX_W-1:0]       cur_idx;
    logic [CNT_W-1:0]        cnt_cur;
    logic [CNT_W-1:0]        reload_cur;
    logic [1:0]              sel_cur;
    logic                    cascade_cur;
    logic                    irq_en_cur;
    logic                    run_cur;
    logic [ACC_W-1:0]        acc_cur;
    logic                    is_first;
    logic                    is_source;
    logic                    is_chained;
    logic [TICK_W-1:0]       total;
    logic [TICK_W-1:0]       ticks_src;
    logic [ACC_W-1:0]        acc_src;
    logic [TICK_W-1:0]       ticks;
    logic [CNT_W:0]          d0;
    logic                    no_wrap;
    logic [TICK_W-1:0]       wraps;
    logic                    in_accept;
    logic                    k_last;

    logic                    div_start;
    logic [TICK_W-1:0]       div_dividend;
    logic [CNT_W:0]          div_divisor;
    div_res_t                div_res;

    cptb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .res      (div_res)
    );

    assign port_idx    = TIDX_W'(timer_index);
    assign port_idx_ok = (32'(timer_index) < NUM_TIMERS);
    assign in_stall    = (state_reg != ST_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign k_last      = (k_reg == TIDX_W'(NUM_TIMERS - 1));
    assign is_first    = (k_reg == '0);

    // Pick the timer that the current step works on.
    always_comb
    begin
        case (state_reg)
            ST_IDLE:   cur_idx = port_idx;
            ST_REPORT: cur_idx = idx_reg;
            default:   cur_idx = k_reg;
        endcase
        cnt_cur     = cnt_reg[cur_idx];
        reload_cur  = reload_reg[cur_idx];
        sel_cur     = sel_reg[cur_idx];
        cascade_cur = cascade_reg[cur_idx];
        irq_en_cur  = irq_en_reg[cur_idx];
        run_cur     = run_reg[cur_idx];
        acc_cur     = acc_reg[cur_idx];
    end

    // Prescaler: ticks this timer gets from the advance, and the remainder it keeps.
    always_comb
    begin
        total = TICK_W'(acc_cur) + TICK_W'(cycles_reg);
        case (sel_cur)
            PS_DIV64:
            begin
                ticks_src = total >> 6;
                acc_src   = ACC_W'(total[5:0]);
            end
            PS_DIV256:
            begin
                ticks_src = total >> 8;
                acc_src   = ACC_W'(total[7:0]);
            end
            PS_DIV1024:
            begin
                ticks_src = total >> 10;
                acc_src   = total[ACC_W-1:0];
            end
            default:
            begin
                ticks_src = total;
                acc_src   = '0;
            end
        endcase
        is_source  = run_cur && (is_first || !cascade_cur);
        is_chained = run_cur && !is_first && cascade_cur;
        if (is_source)
        begin
            ticks = ticks_src;
        end
        else if (is_chained)
        begin
            ticks = kprev_reg;
        end
        else
        begin
            ticks = '0;
        end
        // Ticks until the first wrap, and the ticks left after it.
        d0           = WRAP - {1'b0, cnt_cur};
        no_wrap      = (32'(ticks) < 32'(d0));
        div_dividend = TICK_W'(32'(ticks) - 32'(d0));
        div_divisor  = WRAP - {1'b0, reload_cur};
        wraps        = div_res.quot + TICK_W'(1);
    end

    // Sequencer: next state, timer updates and result assembly.
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        kind_next      = kind_reg;
        idx_next       = idx_reg;
        idx_ok_next    = idx_ok_reg;
        cycles_next    = cycles_reg;
        kprev_next     = kprev_reg;
        irq_acc_next   = irq_acc_reg;
        ovf0_next      = ovf0_reg;
        ovf1_next      = ovf1_reg;
        irq_out_next   = irq_out_reg;
        ovf0_out_next  = ovf0_out_reg;
        ovf1_out_next  = ovf1_out_reg;
        cnt_out_next   = cnt_out_reg;
        out_valid_next = out_valid_reg && out_stall;
        div_start      = 1'b0;
        cnt_next       = cnt_reg;
        reload_next    = reload_reg;
        sel_next       = sel_reg;
        cascade_next   = cascade_reg;
        irq_en_next    = irq_en_reg;
        run_next       = run_reg;
        acc_next       = acc_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    kind_next    = kind_t'(kind);
                    idx_next     = port_idx;
                    idx_ok_next  = port_idx_ok;
                    cycles_next  = cycles;
                    kprev_next   = '0;
                    irq_acc_next = '0;
                    ovf0_next    = '0;
                    ovf1_next    = '0;
                    k_next       = '0;
                    state_next   = ST_REPORT;
                    case (kind_t'(kind))
                        KIND_CTRL:
                        begin
                            if (port_idx_ok)
                            begin
                                sel_next[cur_idx]     = write_value[1:0];
                                cascade_next[cur_idx] = write_value[CTL_CASCADE_BIT];
                                irq_en_next[cur_idx]  = write_value[CTL_IRQ_BIT];
                                run_next[cur_idx]     = write_value[CTL_EN_BIT];
                                // Enable rising: restart from the reload value.
                                if (write_value[CTL_EN_BIT] && !run_cur)
                                begin
                                    cnt_next[cur_idx] = reload_cur;
                                    acc_next[cur_idx] = '0;
                                end
                            end
                        end
                        KIND_RELOAD:
                        begin
                            if (port_idx_ok)
                            begin
                                reload_next[cur_idx] = write_value;
                            end
                        end
                        KIND_ADVANCE:
                        begin
                            state_next = ST_LOAD;
                        end
                        default:
                        begin
                            state_next = ST_REPORT;
                        end
                    endcase
                end
            end

            ST_LOAD:
            begin
                if (is_source)
                begin
                    acc_next[cur_idx] = acc_src;
                end
                if (no_wrap)
                begin
                    // No wrap: just add the ticks; nothing passes down the chain.
                    cnt_next[cur_idx] = CNT_W'(cnt_cur + CNT_W'(ticks));
                    kprev_next        = '0;
                    if (k_last)
                    begin
                        state_next = ST_REPORT;
                    end
                    else
                    begin
                        k_next = k_reg + TIDX_W'(1);
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (div_res.done)
                begin
                    // Wraps = 1 + remaining ticks / reload period; remainder lands
                    // on top of the reload value.
                    cnt_next[cur_idx] = reload_cur + div_res.rem;
                    kprev_next        = wraps;
                    if (irq_en_cur)
                    begin
                        for (int j = 0; j < IRQ_W; j++)
                        begin
                            if (32'(k_reg) == j)
                            begin
                                irq_acc_next[j] = 1'b1;
                            end
                        end
                    end
                    if (is_first)
                    begin
                        ovf0_next = ovf_sat(wraps);
                    end
                    if (k_reg == TIDX_W'(1))
                    begin
                        ovf1_next = ovf_sat(wraps);
                    end
                    if (k_last)
                    begin
                        state_next = ST_REPORT;
                    end
                    else
                    begin
                        k_next     = k_reg + TIDX_W'(1);
                        state_next = ST_LOAD;
                    end
                end
            end

            ST_REPORT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    irq_out_next   = irq_acc_reg;
                    ovf0_out_next  = ovf0_reg;
                    ovf1_out_next  = ovf1_reg;
                    cnt_out_next   = idx_ok_reg ? cnt_cur : '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and timer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                cnt_reg[i]     <= '0;
                reload_reg[i]  <= '0;
                sel_reg[i]     <= '0;
                cascade_reg[i] <= 1'b0;
                irq_en_reg[i]  <= 1'b0;
                run_reg[i]     <= 1'b0;
                acc_reg[i]     <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            reload_reg    <= reload_next;
            sel_reg       <= sel_next;
            cascade_reg   <= cascade_next;
            irq_en_reg    <= irq_en_next;
            run_reg       <= run_next;
            acc_reg       <= acc_next;
        end
    end

    // Item and result payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        idx_reg      <= idx_next;
        idx_ok_reg   <= idx_ok_next;
        cycles_reg   <= cycles_next;
        kprev_reg    <= kprev_next;
        irq_acc_reg  <= irq_acc_next;
        ovf0_reg     <= ovf0_next;
        ovf1_reg     <= ovf1_next;
        irq_out_reg  <= irq_out_next;
        ovf0_out_reg <= ovf0_out_next;
        ovf1_out_reg <= ovf1_out_next;
        cnt_out_reg  <= cnt_out_next;
    end

    assign out_valid        = out_valid_reg;
    assign irq_raised       = irq_out_reg;
    assign timer0_overflows = ovf0_out_reg;
    assign timer1_overflows = ovf1_out_reg;
    assign counter_value    = cnt_out_reg;

    // The divider only reports back while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> state_reg == ST_DIV)
        else $error("divider result arrived outside the wait state");

    // Each advance starts with no carried wraps and no raised interrupts.
    a_first_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && k_reg == '0) |-> (kprev_reg == '0 && irq_acc_reg == '0))
        else $error("advance started with stale accumulators");

    // Write items report no interrupts and no overflows.
    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPORT && kind_reg != KIND_ADVANCE)
            |-> (irq_acc_reg == '0 && ovf0_reg == '0 && ovf1_reg == '0))
        else $error("write item reported overflow activity");

    // Only an advance item ever uses the divider.
    a_div_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (kind_reg == KIND_ADVANCE))
        else $error("divider used for a non-advance item");

endmodule
